// ===== rtl/core/pfa_pkg.sv =====
// Shared types and constants of the physical frame allocator.
package pfa_pkg;

	localparam int FRAME_BITS     = 40;
	localparam int STATUS_BITS    = 2;
	localparam int CFG_INDEX_BITS = 3;

	typedef logic [FRAME_BITS-1:0]  frame_t;
	typedef logic [STATUS_BITS-1:0] status_t;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// status codes
	localparam status_t ST_OK   = 2'd0;
	localparam status_t ST_OOM  = 2'd1;
	localparam status_t ST_DROP = 2'd2;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_REGION0_FIRST  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_REGION0_LAST   = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_REGION1_FIRST  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_REGION1_LAST   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RESERVED_FIRST = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RESERVED_LAST  = 3'd5;

	typedef struct packed {
		logic   cmd;
		frame_t free_frame;
	} pfa_req_t;

	typedef struct packed {
		frame_t  frame;
		status_t status;
	} pfa_res_t;

	typedef struct packed {
		frame_t region0_first;
		frame_t region0_last;
		frame_t region1_first;
		frame_t region1_last;
		frame_t reserved_first;
		frame_t reserved_last;
	} pfa_cfg_t;

	typedef struct packed {
		logic empty;
		logic full;
	} pfa_qstat_t;

	typedef struct packed {
		logic   finished;
		logic   ok;
		frame_t frame;
	} pfa_bump_res_t;

endpackage

// ===== rtl/core/pfa_free_queue.sv =====
// FIFO of freed frame numbers held in a synchronous memory.
module pfa_free_queue #(
	parameter int DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                pop,
	input  pfa_pkg::frame_t     push_data,
	output pfa_pkg::frame_t     rd_data,
	output pfa_pkg::pfa_qstat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	pfa_pkg::frame_t mem [DEPTH];
	pfa_pkg::frame_t rd_data_q;

	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= push_data;
		end
		if (pop) begin
			rd_data_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= ptr_next(tail_q);
			end
			if (pop) begin
				head_q <= ptr_next(head_q);
			end
			// push and pop never fall in the same cycle
			if (push) begin
				count_q <= count_q + 1'b1;
			end else if (pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_data    = rd_data_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(DEPTH));

endmodule

// ===== rtl/core/pfa_bump.sv =====
// Bump cursor over the two regions; one region try per step.
module pfa_bump (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  pfa_pkg::pfa_cfg_t      cfg,
	output pfa_pkg::pfa_bump_res_t res
);

	pfa_pkg::frame_t cursor_q;
	logic [1:0]      region_q;

	pfa_pkg::frame_t first, last, c_clamp, c_pick;
	logic            rsv_valid, rsv_hit, over, skip, end_mark, used_up;
	logic            adv_region, take;

	always_comb begin
		first = region_q[0] ? cfg.region1_first : cfg.region0_first;
		last  = region_q[0] ? cfg.region1_last  : cfg.region0_last;

		used_up  = region_q[1];
		end_mark = (first == '0) && (last == '0);

		c_clamp   = (cursor_q < first) ? first : cursor_q;
		rsv_valid = (cfg.reserved_first <= cfg.reserved_last);
		rsv_hit   = rsv_valid && (c_clamp >= cfg.reserved_first) &&
			(c_clamp <= cfg.reserved_last);
		over      = rsv_hit && (cfg.reserved_last >= last);
		c_pick    = (rsv_hit && !over) ? cfg.reserved_last + 1'b1 : c_clamp;
		// a jump past the reserved range stays inside the region here
		skip      = over || (!rsv_hit && (c_clamp > last));

		take       = !used_up && !end_mark && !skip;
		adv_region = !used_up && !end_mark && (skip || (c_pick == last));

		res.finished = used_up || end_mark || !skip;
		res.ok       = take;
		res.frame    = c_pick;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			region_q <= 2'd0;
		end else if (step) begin
			if (adv_region) begin
				if (region_q == 2'd0) begin
					region_q <= 2'd1;
					cursor_q <= cfg.region1_first;
				end else begin
					region_q <= 2'd2;
					cursor_q <= '0;
				end
			end else if (take) begin
				cursor_q <= c_pick + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/physical_frame_allocator.sv =====
// Physical frame allocator: free-frame FIFO backed by a bump cursor over two regions.
// Usage:
//   Commands enter on request when start is high and busy is low. A free command
//   (cmd = 1) pushes free_frame onto the FIFO; an allocate command (cmd = 0) pops
//   the oldest freed frame, or else takes the next frame from the bump cursor.
//   Every command gives one result word on result, marked by done for one cycle.
//   Timing: a free gives its result in the next cycle. An allocate from the FIFO
//   reads the memory into its read register, then registers the result in S_POP;
//   an allocate from the cursor steps through S_BUMP, one region tried per step,
//   up to three tries. busy is high in S_POP and S_BUMP until the result is
//   registered, so a new command may be accepted as soon as busy falls, while
//   done still shows the previous result; a free never raises busy.
//   Throughput: one free per cycle; an allocate holds off new commands while busy.
//   Configuration: cfg_we writes cfg_data to register cfg_index; indexes above
//   five are ignored. Write only while idle.
//   Reset: the FIFO is empty, the cursor sits at region zero, no clearing pass.
//   The receiver cannot stall: done is a single-cycle strobe.
module physical_frame_allocator #(
	parameter int FREE_QUEUE_DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  pfa_pkg::pfa_req_t                     request,
	output logic                                  done,
	output pfa_pkg::pfa_res_t                     result,
	input  logic                                  cfg_we,
	input  logic [pfa_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  pfa_pkg::frame_t                       cfg_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_POP  = 2'd1;
	localparam logic [1:0] S_BUMP = 2'd2;

	logic [1:0] state_q;

	pfa_pkg::pfa_cfg_t      cfg_q;
	pfa_pkg::pfa_qstat_t    qstat;
	pfa_pkg::pfa_bump_res_t bres;
	pfa_pkg::frame_t        q_rd_data;
	pfa_pkg::pfa_res_t      result_q;
	logic                   done_q;

	logic accept, is_free, push, pop, bump_step;

	always_comb begin
		busy      = (state_q != S_IDLE);
		accept    = start && !busy;
		is_free   = (request.cmd == pfa_pkg::CMD_FREE);
		push      = accept && is_free && !qstat.full;
		pop       = accept && !is_free && !qstat.empty;
		bump_step = (state_q == S_BUMP);
	end

	pfa_free_queue #(
		.DEPTH(FREE_QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.pop      (pop),
		.push_data(request.free_frame),
		.rd_data  (q_rd_data),
		.stat     (qstat)
	);

	pfa_bump u_bump (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (bump_step),
		.cfg   (cfg_q),
		.res   (bres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.region0_first  <= '0;
			cfg_q.region0_last   <= '0;
			cfg_q.region1_first  <= '0;
			cfg_q.region1_last   <= '0;
			cfg_q.reserved_first <= pfa_pkg::frame_t'(1);
			cfg_q.reserved_last  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pfa_pkg::REG_REGION0_FIRST:  cfg_q.region0_first  <= cfg_data;
				pfa_pkg::REG_REGION0_LAST:   cfg_q.region0_last   <= cfg_data;
				pfa_pkg::REG_REGION1_FIRST:  cfg_q.region1_first  <= cfg_data;
				pfa_pkg::REG_REGION1_LAST:   cfg_q.region1_last   <= cfg_data;
				pfa_pkg::REG_RESERVED_FIRST: cfg_q.reserved_first <= cfg_data;
				pfa_pkg::REG_RESERVED_LAST:  cfg_q.reserved_last  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && is_free) begin
						done_q <= 1'b1;
					end else if (accept) begin
						state_q <= qstat.empty ? S_BUMP : S_POP;
					end
				end
				S_POP: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_BUMP: begin
					if (bres.finished) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result word; no reset needed, done qualifies it
	always_ff @(posedge clk) begin
		priority if (accept && is_free) begin
			result_q.frame  <= '0;
			result_q.status <= qstat.full ? pfa_pkg::ST_DROP : pfa_pkg::ST_OK;
		end else if (state_q == S_POP) begin
			result_q.frame  <= q_rd_data;
			result_q.status <= pfa_pkg::ST_OK;
		end else if (bump_step && bres.finished) begin
			result_q.frame  <= bres.ok ? bres.frame : '0;
			result_q.status <= bres.ok ? pfa_pkg::ST_OK : pfa_pkg::ST_OOM;
		end else begin
			result_q <= result_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
